>>> src/b64d_pkg.sv
`timescale 1ns / 1ps

package b64d_pkg;

	// Input transaction: one text character
	typedef struct packed {
		logic [7:0] char_code;
		logic       end_of_text;
	} b64_in_t;

	// Output transaction: at most one per character
	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       bad_char;
		logic       final_res;
	} b64_out_t;

	// Character classes found by the front end
	typedef enum logic [1:0] {
		CK_DATA  = 2'd0,
		CK_BLANK = 2'd1,
		CK_PAD   = 2'd2,
		CK_BAD   = 2'd3
	} char_kind_t;

	// Classified character handed from front to back
	typedef struct packed {
		char_kind_t kind;
		logic [5:0] sextet;
		logic       last;
	} cls_item_t;

	// Alphabet offsets
	localparam logic [5:0] SEXT_LOWER = 6'd26;
	localparam logic [5:0] SEXT_DIGIT = 6'd52;
	localparam logic [5:0] SEXT_PLUS  = 6'd62;
	localparam logic [5:0] SEXT_SLASH = 6'd63;

	localparam logic [7:0] CH_PAD   = 8'h3D; // '='
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_D0    = 8'h30;
	localparam logic [7:0] CH_D9    = 8'h39;

	// Depth of the queue between front and back
	localparam int unsigned CQ_DEPTH = 2;

endpackage

>>> src/b64d_front.sv
`timescale 1ns / 1ps

module b64d_front (
	input  b64d_pkg::b64_in_t   in_item,
	output b64d_pkg::cls_item_t cls_item
);
	import b64d_pkg::*;

	logic [7:0] off_upper;
	logic [7:0] off_lower;
	logic [7:0] off_digit;

	assign off_upper = in_item.char_code - CH_UA;
	assign off_lower = in_item.char_code - CH_LA;
	assign off_digit = in_item.char_code - CH_D0;

	// Class and 6-bit value of the character
	always_comb begin
		cls_item.last   = in_item.end_of_text;
		cls_item.sextet = '0;
		cls_item.kind   = CK_BAD;
		priority if (in_item.char_code >= CH_UA && in_item.char_code <= CH_UZ) begin
			cls_item.kind   = CK_DATA;
			cls_item.sextet = off_upper[5:0];
		end else if (in_item.char_code >= CH_LA && in_item.char_code <= CH_LZ) begin
			cls_item.kind   = CK_DATA;
			cls_item.sextet = off_lower[5:0] + SEXT_LOWER;
		end else if (in_item.char_code >= CH_D0 && in_item.char_code <= CH_D9) begin
			cls_item.kind   = CK_DATA;
			cls_item.sextet = off_digit[5:0] + SEXT_DIGIT;
		end else if (in_item.char_code == CH_PLUS) begin
			cls_item.kind   = CK_DATA;
			cls_item.sextet = SEXT_PLUS;
		end else if (in_item.char_code == CH_SLASH) begin
			cls_item.kind   = CK_DATA;
			cls_item.sextet = SEXT_SLASH;
		end else if (in_item.char_code == CH_PAD) begin
			cls_item.kind = CK_PAD;
		end else if (in_item.char_code == CH_CR || in_item.char_code == CH_LF ||
			     in_item.char_code == CH_SPACE || in_item.char_code == CH_TAB) begin
			cls_item.kind = CK_BLANK;
		end else begin
			cls_item.kind = CK_BAD;
		end
	end

endmodule

>>> src/b64d_cq.sv
`timescale 1ns / 1ps

module b64d_cq (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  b64d_pkg::cls_item_t wr_item,
	output logic                cq_full,
	input  logic                rd_en,
	output b64d_pkg::cls_item_t rd_item,
	output logic                cq_empty
);
	import b64d_pkg::*;

	localparam int unsigned PW = $clog2(CQ_DEPTH);

	cls_item_t       slot_q [CQ_DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [PW:0]     cnt_q;
	logic            do_wr;
	logic            do_rd;

	assign cq_full  = (cnt_q == (PW+1)'(CQ_DEPTH));
	assign cq_empty = (cnt_q == '0);
	assign do_wr    = wr_en && !cq_full;
	assign do_rd    = rd_en && !cq_empty;
	assign rd_item  = slot_q[rptr_q];

	// Storage slots
	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wptr_q] <= wr_item;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_wr) begin
				wptr_q <= (wptr_q == PW'(CQ_DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (do_rd) begin
				rptr_q <= (rptr_q == PW'(CQ_DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (PW+1)'(do_wr) - (PW+1)'(do_rd);
		end
	end

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= (PW+1)'(CQ_DEPTH))
		else $error("queue count out of range");

	a_cnt_track: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue count missed a write");

	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == (PW+1)'(CQ_DEPTH)) |-> wptr_q == rptr_q)
		else $error("queue pointers disagree with count");

endmodule

>>> src/b64d_back.sv
`timescale 1ns / 1ps

module b64d_back (
	input  logic                clk,
	input  logic                arst_n,
	input  b64d_pkg::cls_item_t cls_item,
	input  logic                cls_avail,
	output logic                cls_take,
	output b64d_pkg::b64_out_t  out_item,
	output logic                empty,
	input  logic                pop
);
	import b64d_pkg::*;

	logic [5:0]  acc_q;     // pending bits, right aligned, upper bits zero
	logic [1:0]  pend_q;    // pending bit count / 2
	logic        pad_q;
	logic        err_q;
	logic        ovld_q;
	b64_out_t    out_q;

	logic        active;
	logic        have_byte;
	logic        new_err;
	logic        need_res;
	logic        slot_free;
	logic [11:0] word;
	logic [7:0]  byte_val;
	logic [5:0]  acc_nx;
	logic [1:0]  pend_nx;
	logic        pad_nx;
	logic        err_nx;

	assign active    = !pad_q && !err_q;
	assign word      = {acc_q, cls_item.sextet};
	assign slot_free = !ovld_q || pop;

	// Accumulator update for the head character
	always_comb begin
		have_byte = 1'b0;
		new_err   = 1'b0;
		byte_val  = '0;
		acc_nx    = acc_q;
		pend_nx   = pend_q;
		pad_nx    = pad_q;
		err_nx    = err_q;
		if (active) begin
			unique case (cls_item.kind)
				CK_DATA: begin
					unique case (pend_q)
						2'd0: begin
							acc_nx  = cls_item.sextet;
							pend_nx = 2'd3;
						end
						2'd1: begin
							have_byte = 1'b1;
							byte_val  = word[7:0];
							acc_nx    = '0;
							pend_nx   = 2'd0;
						end
						2'd2: begin
							have_byte = 1'b1;
							byte_val  = word[9:2];
							acc_nx    = {4'd0, word[1:0]};
							pend_nx   = 2'd1;
						end
						default: begin
							have_byte = 1'b1;
							byte_val  = word[11:4];
							acc_nx    = {2'd0, word[3:0]};
							pend_nx   = 2'd2;
						end
					endcase
				end
				CK_PAD:   pad_nx = 1'b1;
				CK_BAD: begin
					err_nx  = 1'b1;
					new_err = 1'b1;
				end
				default: ;
			endcase
		end
	end

	assign need_res = cls_item.last || have_byte || new_err;
	assign cls_take = cls_avail && (!need_res || slot_free);

	// Decoder state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			pend_q <= '0;
			pad_q  <= 1'b0;
			err_q  <= 1'b0;
			ovld_q <= 1'b0;
		end else begin
			if (cls_take) begin
				if (cls_item.last) begin
					acc_q  <= '0;
					pend_q <= '0;
					pad_q  <= 1'b0;
					err_q  <= 1'b0;
				end else begin
					acc_q  <= acc_nx;
					pend_q <= pend_nx;
					pad_q  <= pad_nx;
					err_q  <= err_nx;
				end
			end
			if (cls_take && need_res) begin
				ovld_q <= 1'b1;
			end else if (pop) begin
				ovld_q <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (cls_take && need_res) begin
			out_q.data_byte  <= byte_val;
			out_q.byte_valid <= have_byte;
			out_q.bad_char   <= new_err || (cls_item.last && err_q);
			out_q.final_res  <= cls_item.last;
		end
	end

	assign out_item = out_q;
	assign empty    = !ovld_q;

	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cls_take && cls_item.last) |=> (pend_q == '0 && !pad_q && !err_q))
		else $error("end of text left decoder state behind");

	a_pad_err_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(pad_q && err_q))
		else $error("padding and error both set");

	a_acc_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(pend_q != 2'd0 || acc_q == '0) && (pend_q != 2'd1 || acc_q[5:2] == '0))
		else $error("accumulator holds bits beyond pending count");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(ovld_q && !pop) |-> !(cls_take && need_res))
		else $error("result register overwritten while held");

endmodule

>>> src/base64_stream_decoder_top.sv
`timescale 1ns / 1ps

// Streaming base64 decoder, one text character per transaction.
// Input channel: in_item carries char_code and end_of_text; a transaction
// happens on a clock edge with push high and full low.
// Output channel: out_item holds the oldest result while empty is low; it is
// consumed on a clock edge with pop high and empty low. A result carries a
// decoded byte, an invalid-character flag and/or the end-of-text flag.
// Whitespace, '=' and characters after padding or an error give no result
// unless they end the text; end_of_text always gives exactly one result.
// A result is registered in the output register when its character is taken
// by the back end, and it can be popped once it is visible.
// Throughput: one character per cycle unless the receiver stalls, set by the accumulator
// update in the back end; a two-entry queue parts the classifier front end
// from that update, and one output register holds the result.
// When the receiver stalls, the output register and then the queue fill,
// after which full rises; characters that give no result still drain.
// Reset (arst_n low) empties the queue and output and clears the decoder
// state: no pending bits, no padding, no error.

module base64_stream_decoder_top (
	input  logic               clk,
	input  logic               arst_n,
	input  b64d_pkg::b64_in_t  in_item,
	input  logic               push,
	output logic               full,
	output b64d_pkg::b64_out_t out_item,
	output logic               empty,
	input  logic               pop
);
	import b64d_pkg::*;

	cls_item_t front_cls;
	cls_item_t head_cls;
	logic      cq_empty;
	logic      head_take;

	b64d_front u_front (
		.in_item  (in_item),
		.cls_item (front_cls)
	);

	b64d_cq u_cq (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (front_cls),
		.cq_full  (full),
		.rd_en    (head_take),
		.rd_item  (head_cls),
		.cq_empty (cq_empty)
	);

	b64d_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cls_item  (head_cls),
		.cls_avail (!cq_empty),
		.cls_take  (head_take),
		.out_item  (out_item),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
